// ----- rtl/radio_core_command_sequencer_core_macros.svh -----
// Assertion macros for the radio core command sequencer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef RADIO_CORE_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define RADIO_CORE_COMMAND_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define RCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcs: check failed");

// next-cycle implication
`define RCS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcs: check failed");

`endif

// ----- rtl/rcs_pkg.sv -----
// Types, codes and constants for the radio core command sequencer.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package rcs_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int TMO_W      = 16;

  // commands
  localparam logic [2:0] CMD_POLL      = 3'd0;
  localparam logic [2:0] CMD_POWER_ON  = 3'd1;
  localparam logic [2:0] CMD_POWER_OFF = 3'd2;
  localparam logic [2:0] CMD_IMMEDIATE = 3'd3;
  localparam logic [2:0] CMD_RADIO_OP  = 3'd4;
  localparam logic [2:0] CMD_CHAIN     = 3'd5;
  localparam logic [2:0] CMD_READ_ERR  = 3'd6;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POWER = 3'd1;
  localparam logic [2:0] ST_BOOT  = 3'd2;
  localparam logic [2:0] ST_READY = 3'd3;
  localparam logic [2:0] ST_ACK   = 3'd4;
  localparam logic [2:0] ST_OP    = 3'd5;
  localparam logic [2:0] ST_ERR   = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_POWER    = 3'd1;
  localparam logic [2:0] ERR_BOOT     = 3'd2;
  localparam logic [2:0] ERR_UNRESP   = 3'd3;
  localparam logic [2:0] ERR_PARSE    = 3'd4;
  localparam logic [2:0] ERR_OP       = 3'd5;
  localparam logic [2:0] ERR_INTERNAL = 3'd6;
  localparam logic [2:0] ERR_SYNTH    = 3'd7;

  // core flag bits
  localparam int FL_BOOT  = 0;
  localparam int FL_INT   = 1;
  localparam int FL_DONE  = 2;
  localparam int FL_LAST  = 3;
  localparam int FL_RXNOK = 4;
  localparam int FL_SYNTH = 5;

  // register indexes
  localparam logic [1:0] REG_POWER_ON_TMO = 2'd0;
  localparam logic [1:0] REG_BOOT_TMO     = 2'd1;
  localparam logic [1:0] REG_ACK_TMO      = 2'd2;

  localparam logic [TMO_W-1:0] TMO_RESET = 16'd10;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [31:0]      command_word;
    logic [TMO_W-1:0] radio_timeout_ms;
    logic             ms_tick;
    logic             power_is_on;
    logic             core_ready;
    logic             core_ack;
    logic             cmd_status_done;
    logic [5:0]       core_flags;
    logic             op_status_error;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  state_out;
    logic        ready_out;
    logic [2:0]  error_out;
    logic        power_request;
    logic        issue_strobe;
    logic [31:0] command_out;
    logic        abort_strobe;
    logic        rx_crc_error;
  } out_item_t;

  typedef struct packed {
    logic [TMO_W-1:0] power_on_timeout_ms;
    logic [TMO_W-1:0] boot_timeout_ms;
    logic [TMO_W-1:0] ack_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       fsm;
    logic             booted;
    logic             radio_op_mode;
    logic             chain_mode;
    logic [TMO_W-1:0] op_timeout_setting;
    logic [TMO_W-1:0] timeout_left;
    logic [2:0]       error_code;
    logic [31:0]      held_command;
    logic             power_level;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    fsm:                ST_IDLE,
    booted:             1'b0,
    radio_op_mode:      1'b0,
    chain_mode:         1'b0,
    op_timeout_setting: '0,
    timeout_left:       '0,
    error_code:         ERR_NONE,
    held_command:       '0,
    power_level:        1'b0
  };

endpackage

`default_nettype wire

// ----- rtl/rcs_ifs.sv -----
// Valid/ready channel interfaces for request beats and result beats.
// Depends on rcs_pkg for the payload types.
`default_nettype none

interface rcs_in_if;
  import rcs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rcs_out_if;
  import rcs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/rcs_regs.sv -----
// APB configuration registers: power-on, boot and ack timeouts.
// Depends on rcs_pkg.
`default_nettype none

module rcs_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rcs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rcs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output rcs_pkg::cfg_t                  cfg
);
  import rcs_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_on_timeout_ms <= TMO_RESET;
      cfg.boot_timeout_ms     <= TMO_RESET;
      cfg.ack_timeout_ms      <= TMO_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POWER_ON_TMO: cfg.power_on_timeout_ms <= pwdata[TMO_W-1:0];
        REG_BOOT_TMO:     cfg.boot_timeout_ms     <= pwdata[TMO_W-1:0];
        REG_ACK_TMO:      cfg.ack_timeout_ms      <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_POWER_ON_TMO: prdata[TMO_W-1:0] = cfg.power_on_timeout_ms;
      REG_BOOT_TMO:     prdata[TMO_W-1:0] = cfg.boot_timeout_ms;
      REG_ACK_TMO:      prdata[TMO_W-1:0] = cfg.ack_timeout_ms;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rcs_step.sv -----
// Next-state and result logic for one beat of the sequencer.
// Purely combinational; depends on rcs_pkg.
`default_nettype none

module rcs_step (
  input  rcs_pkg::seq_state_t st,
  input  rcs_pkg::cfg_t       cfg,
  input  rcs_pkg::in_item_t   item,
  output rcs_pkg::seq_state_t nxt,
  output rcs_pkg::out_item_t  res
);
  import rcs_pkg::*;

  logic [TMO_W-1:0] tl_dec;
  logic             expired;
  logic             start_ok;
  logic             do_issue;
  logic             do_fail;
  logic [2:0]       fail_code;
  logic             abort;
  logic             rxcrc;
  logic             acc;
  logic             op_done;
  logic [5:0]       fl;

  always_comb begin
    nxt       = st;
    fl        = item.core_flags;
    tl_dec    = st.timeout_left;
    if (item.ms_tick && st.timeout_left != '0) begin
      tl_dec = st.timeout_left - 1'b1;
    end
    nxt.timeout_left = tl_dec;
    expired   = (tl_dec == '0);
    start_ok  = (st.fsm == ST_IDLE) && st.booted;
    do_issue  = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    abort     = 1'b0;
    rxcrc     = 1'b0;
    acc       = 1'b0;
    op_done   = (fl[FL_DONE] || fl[FL_LAST]) && (!st.chain_mode || fl[FL_LAST]);

    unique case (item.cmd)
      CMD_POLL: begin
        unique case (st.fsm)
          ST_POWER: begin
            if (item.power_is_on) begin
              nxt.timeout_left = cfg.boot_timeout_ms;
              nxt.fsm          = ST_BOOT;
            end else if (expired) begin
              do_fail = 1'b1; fail_code = ERR_POWER;
            end
          end
          ST_BOOT: begin
            if (fl[FL_BOOT]) begin
              nxt.booted = 1'b1;
              nxt.fsm    = ST_IDLE;
            end else if (fl[FL_INT] || expired) begin
              do_fail = 1'b1; fail_code = ERR_BOOT;
            end
          end
          ST_READY: begin
            if (item.core_ready) begin
              do_issue = 1'b1;
            end else if (expired) begin
              do_fail = 1'b1; fail_code = ERR_UNRESP;
            end
          end
          ST_ACK: begin
            if (item.core_ack) begin
              if (!item.cmd_status_done) begin
                do_fail = 1'b1; fail_code = ERR_PARSE;
              end else if (st.radio_op_mode) begin
                nxt.fsm          = ST_OP;
                nxt.timeout_left = st.op_timeout_setting;
              end else begin
                nxt.fsm = ST_IDLE;
              end
            end else if (expired) begin
              do_fail = 1'b1; fail_code = ERR_UNRESP;
            end
          end
          ST_OP: begin
            priority if (op_done) begin
              if (st.chain_mode || !item.op_status_error) begin
                nxt.fsm = ST_IDLE;
              end else begin
                do_fail = 1'b1; fail_code = ERR_OP;
              end
            end else if (fl[FL_RXNOK]) begin
              abort   = 1'b1;
              rxcrc   = 1'b1;
              nxt.fsm = ST_IDLE;
            end else if (fl[FL_INT] || fl[FL_SYNTH]) begin
              do_fail   = 1'b1;
              fail_code = fl[FL_SYNTH] ? ERR_SYNTH : ERR_INTERNAL;
            end else if (st.op_timeout_setting != '0 && expired) begin
              do_fail = 1'b1; fail_code = ERR_UNRESP;
            end else begin
              // operation still running
            end
          end
          ST_ERR: begin
            if (st.error_code == ERR_NONE) begin
              nxt.fsm = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_POWER_ON: begin
        if (st.fsm == ST_IDLE && !item.power_is_on) begin
          nxt.power_level  = 1'b1;
          nxt.timeout_left = cfg.power_on_timeout_ms;
          nxt.fsm          = ST_POWER;
          acc              = 1'b1;
        end
      end
      CMD_POWER_OFF: begin
        if ((st.error_code != ERR_NONE || st.fsm == ST_IDLE) && item.power_is_on) begin
          nxt.power_level = 1'b0;
          nxt.booted      = 1'b0;
          acc             = 1'b1;
        end
      end
      CMD_IMMEDIATE, CMD_RADIO_OP, CMD_CHAIN: begin
        if (start_ok) begin
          acc              = 1'b1;
          nxt.held_command = item.command_word;
          nxt.timeout_left = cfg.ack_timeout_ms;
          if (item.cmd == CMD_IMMEDIATE) begin
            nxt.radio_op_mode = 1'b0;
          end else begin
            nxt.radio_op_mode      = 1'b1;
            nxt.op_timeout_setting = item.radio_timeout_ms;
          end
          if (item.cmd == CMD_CHAIN) begin
            nxt.chain_mode = 1'b1;
          end
          if (item.core_ready) begin
            do_issue = 1'b1;
          end else begin
            nxt.fsm = ST_READY;
          end
        end
      end
      CMD_READ_ERR: ;
      default: ;
    endcase

    if (do_issue) begin
      nxt.timeout_left = cfg.ack_timeout_ms;
      nxt.fsm          = ST_ACK;
    end

    if (do_fail) begin
      abort          = 1'b1;
      nxt.error_code = fail_code;
      nxt.fsm        = ST_ERR;
      if (item.power_is_on) begin
        nxt.power_level = 1'b0;
        nxt.booted      = 1'b0;
      end
    end

    res               = '0;
    res.error_out     = nxt.error_code;
    if (item.cmd == CMD_READ_ERR) begin
      nxt.error_code = ERR_NONE;
      acc            = 1'b1;
    end
    res.accepted      = acc;
    res.state_out     = nxt.fsm;
    res.ready_out     = (nxt.fsm == ST_IDLE) && nxt.booted;
    res.power_request = nxt.power_level;
    res.issue_strobe  = do_issue;
    res.command_out   = do_issue ? nxt.held_command : '0;
    res.abort_strobe  = abort;
    res.rx_crc_error  = rxcrc;
  end

endmodule

`default_nettype wire

// ----- rtl/radio_core_command_sequencer_core.sv -----
// Radio core command sequencer, top level.
// A request beat is held in the input register; its result beat is held in the result register.
// Throughput: one beat per cycle while the result channel is not stalled; the step logic
// between the input and result registers is combinational and runs the whole state update.
// Reset (rst, synchronous): sequencer idle, not booted, error none, power request
// low, timeouts 10 ms; both pipeline registers empty.
`default_nettype none
`include "radio_core_command_sequencer_core_macros.svh"

module radio_core_command_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  rcs_in_if.sink                         in_ch,
  rcs_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rcs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rcs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rcs_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  out_item_t  step_res;
  in_item_t   in_item;
  logic       in_valid;
  out_item_t  out_item;
  logic       out_valid;
  logic       advance;

  rcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcs_step u_step (
    .st   (state),
    .cfg  (cfg),
    .item (in_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  assign advance        = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready    = !in_valid || advance;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item <= in_ch.payload;
    end
    if (advance) begin
      out_item <= step_res;
    end
  end

  `RCS_ASSERT_IMP(a_stall_blocks_in, clk, rst, in_valid && out_valid && !out_ch.ready, !in_ch.ready)
  `RCS_ASSERT_NXT(a_issue_to_ack, clk, rst, advance && step_res.issue_strobe, state.fsm == ST_ACK)
  `RCS_ASSERT_NXT(a_err_entry_aborts, clk, rst, advance && state.fsm != ST_ERR && !step_res.abort_strobe, state.fsm != ST_ERR)
  `RCS_ASSERT_IMP(a_ready_only_idle, clk, rst, out_ch.valid && out_ch.payload.ready_out, out_ch.payload.state_out == ST_IDLE)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for radio_core_command_sequencer_core: directed and random request beats,
// each status beat compared with an in-bench model of the sequencer; timeouts set over APB.
// Depends on rcs_pkg, rcs_ifs and the sequencer RTL.

module tb_top;
  import rcs_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [5:0] F_BOOT  = 6'(1 << FL_BOOT);
  localparam logic [5:0] F_INT   = 6'(1 << FL_INT);
  localparam logic [5:0] F_DONE  = 6'(1 << FL_DONE);
  localparam logic [5:0] F_LAST  = 6'(1 << FL_LAST);
  localparam logic [5:0] F_RXNOK = 6'(1 << FL_RXNOK);
  localparam logic [5:0] F_SYNTH = 6'(1 << FL_SYNTH);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rcs_in_if  in_ch();
  rcs_out_if out_ch();

  radio_core_command_sequencer_core dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // sequencer model
  cfg_t       cfg = '{TMO_RESET, TMO_RESET, TMO_RESET};
  seq_state_t sq  = STATE_RESET;
  logic       sq_issue, sq_abort, sq_rxcrc;

  out_item_t  status_due[$];
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         mismatches = 0;
  int         beats_sent = 0;
  int         results_seen = 0;
  int         writes_done = 0;
  logic [7:0] codes_hit = '0;

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void raise_error(input logic [2:0] code, input logic pw);
    sq_abort = 1'b1;
    sq.error_code = code;
    if (pw) begin
      sq.power_level = 1'b0;
      sq.booted = 1'b0;
    end
    sq.fsm = ST_ERR;
  endfunction

  function automatic void issue_command();
    sq_issue = 1'b1;
    sq.timeout_left = cfg.ack_timeout_ms;
    sq.fsm = ST_ACK;
  endfunction

  function automatic void start_command(input logic [31:0] word, input logic rdy);
    sq.held_command = word;
    if (rdy) begin
      issue_command();
    end else begin
      sq.timeout_left = cfg.ack_timeout_ms;
      sq.fsm = ST_READY;
    end
  endfunction

  function automatic out_item_t step_sequencer(input in_item_t b);
    out_item_t  r;
    logic       start_ok;
    logic       expired;
    logic       done;
    logic       pw;
    logic [2:0] err_before;
    r = '0;
    pw = b.power_is_on;
    start_ok = (sq.fsm == ST_IDLE) && sq.booted;
    sq_issue = 1'b0;
    sq_abort = 1'b0;
    sq_rxcrc = 1'b0;
    if (b.ms_tick && sq.timeout_left != '0) sq.timeout_left = sq.timeout_left - 1'b1;
    expired = (sq.timeout_left == '0);
    case (b.cmd)
      CMD_POLL: begin
        case (sq.fsm)
          ST_POWER: begin
            if (pw) begin
              sq.timeout_left = cfg.boot_timeout_ms;
              sq.fsm = ST_BOOT;
            end else if (expired) begin
              raise_error(ERR_POWER, pw);
            end
          end
          ST_BOOT: begin
            if (b.core_flags[FL_BOOT]) begin
              sq.booted = 1'b1;
              sq.fsm = ST_IDLE;
            end else if (b.core_flags[FL_INT] || expired) begin
              raise_error(ERR_BOOT, pw);
            end
          end
          ST_READY: begin
            if (b.core_ready) issue_command();
            else if (expired) raise_error(ERR_UNRESP, pw);
          end
          ST_ACK: begin
            if (b.core_ack) begin
              if (!b.cmd_status_done) begin
                raise_error(ERR_PARSE, pw);
              end else if (sq.radio_op_mode) begin
                sq.fsm = ST_OP;
                sq.timeout_left = sq.op_timeout_setting;
              end else begin
                sq.fsm = ST_IDLE;
              end
            end else if (expired) begin
              raise_error(ERR_UNRESP, pw);
            end
          end
          ST_OP: begin
            done = (b.core_flags[FL_DONE] || b.core_flags[FL_LAST]) &&
                   (!sq.chain_mode || b.core_flags[FL_LAST]);
            if (done) begin
              if (sq.chain_mode || !b.op_status_error) sq.fsm = ST_IDLE;
              else raise_error(ERR_OP, pw);
            end else if (b.core_flags[FL_RXNOK]) begin
              sq_abort = 1'b1;
              sq_rxcrc = 1'b1;
              sq.fsm = ST_IDLE;
            end else if (b.core_flags[FL_SYNTH]) begin
              raise_error(ERR_SYNTH, pw);
            end else if (b.core_flags[FL_INT]) begin
              raise_error(ERR_INTERNAL, pw);
            end else if (sq.op_timeout_setting != '0 && expired) begin
              raise_error(ERR_UNRESP, pw);
            end
          end
          ST_ERR: begin
            if (sq.error_code == ERR_NONE) sq.fsm = ST_IDLE;
          end
          default: ;
        endcase
      end
      CMD_POWER_ON: begin
        if (sq.fsm == ST_IDLE && !pw) begin
          sq.power_level = 1'b1;
          sq.timeout_left = cfg.power_on_timeout_ms;
          sq.fsm = ST_POWER;
          r.accepted = 1'b1;
        end
      end
      CMD_POWER_OFF: begin
        if ((sq.error_code != ERR_NONE || sq.fsm == ST_IDLE) && pw) begin
          sq.power_level = 1'b0;
          sq.booted = 1'b0;
          r.accepted = 1'b1;
        end
      end
      CMD_IMMEDIATE: begin
        if (start_ok) begin
          sq.radio_op_mode = 1'b0;
          start_command(b.command_word, b.core_ready);
          r.accepted = 1'b1;
        end
      end
      CMD_RADIO_OP, CMD_CHAIN: begin
        if (start_ok) begin
          sq.radio_op_mode = 1'b1;
          sq.op_timeout_setting = b.radio_timeout_ms;
          start_command(b.command_word, b.core_ready);
          if (b.cmd == CMD_CHAIN) sq.chain_mode = 1'b1;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    err_before = sq.error_code;
    if (b.cmd == CMD_READ_ERR) begin
      sq.error_code = ERR_NONE;
      r.accepted = 1'b1;
    end
    r.state_out     = sq.fsm;
    r.ready_out     = (sq.fsm == ST_IDLE) && sq.booted;
    r.error_out     = err_before;
    r.power_request = sq.power_level;
    r.issue_strobe  = sq_issue;
    r.command_out   = sq_issue ? sq.held_command : 32'd0;
    r.abort_strobe  = sq_abort;
    r.rx_crc_error  = sq_rxcrc;
    return r;
  endfunction

  function automatic string show(input out_item_t o);
    return $sformatf("acc=%0b st=%0d rdy=%0b err=%0d pwr=%0b iss=%0b cmd=%08h abt=%0b crc=%0b",
                     o.accepted, o.state_out, o.ready_out, o.error_out, o.power_request,
                     o.issue_strobe, o.command_out, o.abort_strobe, o.rx_crc_error);
  endfunction

  // request monitor: predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      status_due.push_back(step_sequencer(in_ch.payload));
      beats_sent++;
    end
  end

  // status checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (status_due.size() == 0) begin
        log_mismatch($sformatf("status beat %0d with nothing expected: %s",
                               results_seen, show(out_ch.payload)));
      end else begin
        want = status_due.pop_front();
        if (out_ch.payload !== want) begin
          log_mismatch($sformatf("beat %0d\n  exp %s\n  got %s", results_seen, show(want),
                                 show(out_ch.payload)));
        end
        if (want.error_out != ERR_NONE) codes_hit[want.error_out] = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic in_item_t mk(input logic [2:0] c, input logic [31:0] word,
                                  input logic [TMO_W-1:0] tmo, input logic tick,
                                  input logic pw, input logic rdy, input logic ack,
                                  input logic sta, input logic [5:0] flags,
                                  input logic operr);
    in_item_t b;
    b.cmd = c;
    b.command_word = word;
    b.radio_timeout_ms = tmo;
    b.ms_tick = tick;
    b.power_is_on = pw;
    b.core_ready = rdy;
    b.core_ack = ack;
    b.cmd_status_done = sta;
    b.core_flags = flags;
    b.op_status_error = operr;
    return b;
  endfunction

  // mostly well-formed traffic steered by the model state, some noise
  function automatic in_item_t pick_beat(input bit allow_chain);
    in_item_t    b;
    int unsigned roll;
    int unsigned r2;
    b.cmd = CMD_POLL;
    b.command_word = $urandom;
    b.radio_timeout_ms = ($urandom_range(9) == 0) ? TMO_W'($urandom) :
                                                     TMO_W'($urandom_range(12));
    b.ms_tick = 1'($urandom_range(1));
    b.power_is_on = 1'($urandom_range(1));
    b.core_ready = 1'($urandom_range(1));
    b.core_ack = 1'($urandom_range(1));
    b.cmd_status_done = ($urandom_range(5) != 0);
    b.core_flags = '0;
    b.op_status_error = ($urandom_range(3) == 0);
    roll = $urandom_range(99);
    r2 = $urandom_range(99);
    if (roll < 12) begin
      b.cmd = 3'($urandom_range(7));
      if (!allow_chain && b.cmd == CMD_CHAIN) b.cmd = CMD_POLL;
      b.core_flags = 6'($urandom);
      return b;
    end
    case (sq.fsm)
      ST_IDLE: begin
        if (!sq.booted) begin
          if (roll < 85) begin
            b.cmd = CMD_POWER_ON;
            b.power_is_on = (roll >= 80);
          end
        end else if (roll < 40) begin
          b.cmd = CMD_RADIO_OP;
        end else if (roll < 58) begin
          b.cmd = CMD_IMMEDIATE;
        end else if (roll < 68) begin
          b.cmd = allow_chain ? CMD_CHAIN : CMD_RADIO_OP;
        end else if (roll < 80) begin
          b.core_flags = 6'($urandom);
        end else if (roll < 88) begin
          b.cmd = CMD_POWER_OFF;
          b.power_is_on = 1'b1;
        end else begin
          b.cmd = CMD_READ_ERR;
        end
      end
      ST_POWER: b.power_is_on = (roll < 70);
      ST_BOOT: begin
        b.core_flags = 6'($urandom) & ~(F_BOOT | F_INT);
        if (r2 < 55) b.core_flags |= F_BOOT;
        else if (r2 < 62) b.core_flags |= F_INT;
      end
      ST_OP: begin
        if (r2 < 40) b.core_flags = 6'($urandom);
        else if (r2 < 45) b.core_flags = F_RXNOK;
      end
      ST_ERR: begin
        if (roll < 55) b.cmd = CMD_READ_ERR;
        else if (roll < 65) b.cmd = CMD_POWER_OFF;
      end
      default: ;
    endcase
    return b;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_beat(input in_item_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [1:0] idx, input logic [TMO_W-1:0] val);
    logic [APB_DATA_W-1:0] rd;
    rd = '0;
    for (int pass = 0; pass < 2; pass++) begin
      psel = 1'b1;
      penable = 1'b0;
      pwrite = (pass == 0);
      paddr = {idx, 2'b00};
      pwdata = APB_DATA_W'(val);
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      rd = prdata;
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
    end
    case (idx)
      REG_POWER_ON_TMO: cfg.power_on_timeout_ms = val;
      REG_BOOT_TMO:     cfg.boot_timeout_ms = val;
      REG_ACK_TMO:      cfg.ack_timeout_ms = val;
      default: ;
    endcase
    writes_done++;
    if (rd !== APB_DATA_W'(val)) begin
      log_mismatch($sformatf("register %0d read back %08h, wrote %04h", idx, rd, val));
    end
  endtask

  task automatic set_timeouts(input logic [TMO_W-1:0] pwr, input logic [TMO_W-1:0] boot,
                              input logic [TMO_W-1:0] ack);
    write_timeout(REG_POWER_ON_TMO, pwr);
    write_timeout(REG_BOOT_TMO, boot);
    write_timeout(REG_ACK_TMO, ack);
  endtask

  task automatic test_power_up();
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_IMMEDIATE, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 1, 1, 1, 6'h3F, 1));
    send_beat(mk(CMD_POWER_OFF, 0, 0, 0, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POWER_ON, 0, 0, 0, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POWER_ON, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 1, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 0, 0, F_BOOT, 0));
    wait_results_drained();
  endtask

  task automatic test_commands();
    send_beat(mk(CMD_IMMEDIATE, 32'hFFFF_FFFF, 0, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 1, 6'h00, 0));
    // not ready at start, then radio op with no timeout
    send_beat(mk(CMD_RADIO_OP, 32'h0, 16'h0, 0, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 1, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 1, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, F_DONE, 1));
    send_beat(mk(CMD_READ_ERR, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_RADIO_OP, 32'h1234_5678, 16'hFFFF, 1, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 1, 1, 0, 1, 1, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 1, 1, 0, 0, 0, F_LAST, 0));
    wait_results_drained();
  endtask

  task automatic test_errors();
    send_beat(mk(CMD_IMMEDIATE, 32'hA5A5_5A5A, 0, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 0, 6'h00, 0));
    send_beat(mk(CMD_POWER_OFF, 0, 0, 0, 1, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_READ_ERR, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 1, 1, 1, 6'h3F, 1));
    wait_results_drained();
    // power domain never comes up within a 1 ms window
    write_timeout(REG_POWER_ON_TMO, 16'd1);
    send_beat(mk(CMD_POWER_ON, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 1, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_READ_ERR, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    wait_results_drained();
  endtask

  task automatic test_chain();
    while (!(sq.fsm == ST_IDLE && sq.booted)) send_beat(pick_beat(1'b0));
    send_beat(mk(CMD_CHAIN, 32'h8000_0001, 16'd5, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 1, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 0, 0, F_DONE, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 0, 0, F_LAST, 1));
    // plain radio ops now finish as chains
    send_beat(mk(CMD_RADIO_OP, 32'h0BAD_F00D, 16'd3, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 1, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 0, 0, F_RXNOK, 0));
    send_beat(mk(CMD_RADIO_OP, 32'h7FFF_FFFF, 16'd3, 0, 1, 1, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 1, 0, 1, 1, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, F_SYNTH | F_INT, 0));
    send_beat(mk(CMD_READ_ERR, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    send_beat(mk(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 6'h00, 0));
    wait_results_drained();
  endtask

  task automatic test_random(input int src_pct, input int sink_pct, input int count,
                             input bit allow_chain, input bit hold_mid);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) wait_results_drained();
      send_beat(pick_beat(allow_chain));
    end
    wait_results_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_power_up();
    test_commands();
    test_errors();
    set_timeouts(16'd1, 16'd1, 16'd1);
    test_random(0, 0, 300, 1'b0, 1'b0);
    set_timeouts(TMO_W'($urandom_range(2, 40)), TMO_W'($urandom_range(2, 40)),
                 TMO_W'($urandom_range(2, 40)));
    test_random(62, 0, 300, 1'b0, 1'b1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_chain();
    set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(0, 62, 300, 1'b1, 1'b0);
    set_timeouts(TMO_W'($urandom_range(1, 200)), TMO_W'($urandom_range(1, 200)),
                 TMO_W'($urandom_range(1, 200)));
    test_random(20, 20, 300, 1'b1, 1'b0);

    $display("Covered %0d request beats and %0d status beats over four handshake mixes,",
             beats_sent, results_seen);
    $display("%0d timeout register writes; error codes raised (bit per code): %b",
             writes_done, codes_hit);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
